// ----- rtl/ldsf_pkg.sv -----
// Shared types and constants of the LED driver serial framer.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package ldsf_pkg;

    localparam int ADDRESS_BITS = 7;
    localparam int MAX_BITS     = 14;
    localparam int CNT_W        = 4;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QUEUE_AW     = 1;

    localparam int CMD_LEN  = 12;
    localparam int NIB_RAW  = 7 + ADDRESS_BITS;
    localparam int NIB_LEN  = (NIB_RAW > MAX_BITS) ? MAX_BITS : NIB_RAW;
    localparam int BST_LEN  = 3 + ADDRESS_BITS;
    localparam int BYTE_LEN = 8;
    localparam int WIDE_W   = 16;

    localparam logic [2:0] ID_COMMAND = 3'b100;
    localparam logic [2:0] ID_WRITE   = 3'b101;

    typedef enum logic [1:0] {
        MODE_COMMAND = 2'd0,
        MODE_NIBBLE  = 2'd1,
        MODE_BURST   = 2'd2,
        MODE_BYTE    = 2'd3
    } t_mode;

    typedef struct packed {
        logic [MAX_BITS-1:0] word;
        logic [CNT_W-1:0]    len;
        logic                first;
        logic                closes;
    } t_job;

endpackage

`default_nettype wire

// ----- rtl/ldsf_front.sv -----
// Front end: accepts write requests, tracks the open burst and builds serializer jobs.
// Depends on ldsf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ldsf_front (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_accept,
    input  wire logic [1:0]   i_mode,
    input  wire logic [7:0]   i_value,
    input  wire logic [6:0]   i_address,
    input  wire logic         i_last,
    output logic              o_push,
    output ldsf_pkg::t_job    o_job
);
    import ldsf_pkg::*;

    logic                     r_burst_open;
    logic                     n_burst_open;
    logic [7:0]               addr_ext;
    logic [ADDRESS_BITS-1:0]  addr_sel;
    logic [NIB_RAW-1:0]       nib_raw;
    logic [WIDE_W-1:0]        nib_wide;
    logic                     produce;

    assign addr_ext = {1'b0, i_address};
    assign addr_sel = addr_ext[ADDRESS_BITS-1:0];
    assign nib_raw  = {ID_WRITE, addr_sel, i_value[7:4]};
    assign nib_wide = {nib_raw, {(WIDE_W-NIB_RAW){1'b0}}};

    always_comb begin
        n_burst_open = r_burst_open;
        produce      = 1'b1;
        o_job        = '0;
        case (t_mode'(i_mode))
            MODE_COMMAND: begin
                o_job.word   = {ID_COMMAND, i_value, 1'b0, {(MAX_BITS-CMD_LEN){1'b0}}};
                o_job.len    = CNT_W'(CMD_LEN);
                o_job.first  = 1'b1;
                o_job.closes = 1'b1;
                n_burst_open = 1'b0;
            end
            MODE_NIBBLE: begin
                o_job.word   = nib_wide[WIDE_W-1:WIDE_W-MAX_BITS];
                o_job.len    = CNT_W'(NIB_LEN);
                o_job.first  = 1'b1;
                o_job.closes = 1'b1;
                n_burst_open = 1'b0;
            end
            MODE_BURST: begin
                o_job.word   = {ID_WRITE, addr_sel, {(MAX_BITS-BST_LEN){1'b0}}};
                o_job.len    = CNT_W'(BST_LEN);
                o_job.first  = 1'b1;
                o_job.closes = 1'b0;
                n_burst_open = 1'b1;
            end
            MODE_BYTE: begin
                o_job.word   = {i_value, {(MAX_BITS-BYTE_LEN){1'b0}}};
                o_job.len    = CNT_W'(BYTE_LEN);
                o_job.first  = 1'b0;
                o_job.closes = i_last;
                produce      = r_burst_open;
                n_burst_open = r_burst_open & ~i_last;
            end
            default: begin
                produce = 1'b0;
            end
        endcase
    end

    assign o_push = i_accept & produce;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_burst_open <= 1'b0;
        end else if (i_accept) begin
            r_burst_open <= n_burst_open;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/ldsf_queue.sv -----
// Short job queue between the front end and the serializer.
// Depends on ldsf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ldsf_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire ldsf_pkg::t_job i_job,
    input  wire logic          i_pop,
    output logic               o_full,
    output logic               o_valid,
    output ldsf_pkg::t_job     o_job
);
    import ldsf_pkg::*;

    t_job                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;
    logic                do_push;
    logic                do_pop;

    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + (QUEUE_AW+1)'(do_push) - (QUEUE_AW+1)'(do_pop);
        end
    end

    // The fill count never runs past the queue depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QUEUE_AW+1)'(QUEUE_DEPTH))
        else $error("queue count exceeds depth");

    // The front end never offers a job to a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");

endmodule

`default_nettype wire

// ----- rtl/ldsf_back.sv -----
// Serializer: shifts queued jobs out into the result register, one bit per cycle while it is empty or popped.
// Depends on ldsf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ldsf_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_job_valid,
    input  wire ldsf_pkg::t_job i_job,
    output logic                o_job_pop,
    input  wire logic           i_pop,
    output logic                o_empty,
    output logic                o_data_bit,
    output logic                o_frame_start,
    output logic                o_frame_end,
    output logic                o_run_last
);
    import ldsf_pkg::*;

    logic [MAX_BITS-1:0] r_word;
    logic [CNT_W-1:0]    r_left;
    logic                r_closes;
    logic                r_out_valid;
    logic                r_data_bit;
    logic                r_frame_start;
    logic                r_frame_end;
    logic                r_run_last;

    logic                busy;
    logic                have;
    logic                advance;
    logic                emit;
    logic [MAX_BITS-1:0] cur_word;
    logic [CNT_W-1:0]    cur_len;
    logic                cur_first;
    logic                cur_closes;
    logic                cur_final;

    assign busy       = (r_left != '0);
    assign have       = busy | i_job_valid;
    assign advance    = ~r_out_valid | i_pop;
    assign emit       = advance & have;
    assign cur_word   = busy ? r_word : i_job.word;
    assign cur_len    = busy ? r_left : i_job.len;
    assign cur_first  = busy ? 1'b0 : i_job.first;
    assign cur_closes = busy ? r_closes : i_job.closes;
    assign cur_final  = (cur_len == CNT_W'(1));
    assign o_job_pop  = emit & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_left <= cur_len - 1'b1;
            end
            if (advance) begin
                r_out_valid <= have;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_word        <= {cur_word[MAX_BITS-2:0], 1'b0};
            r_closes      <= cur_closes;
            r_data_bit    <= cur_word[MAX_BITS-1];
            r_frame_start <= cur_first;
            r_frame_end   <= cur_final & cur_closes;
            r_run_last    <= cur_final;
        end
    end

    assign o_empty       = ~r_out_valid;
    assign o_data_bit    = r_data_bit;
    assign o_frame_start = r_frame_start;
    assign o_frame_end   = r_frame_end;
    assign o_run_last    = r_run_last;

    // A frame can only end on the final bit of a request.
    a_end_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_frame_end) |-> o_run_last)
        else $error("frame end away from last bit");

    // The remaining bit count stays below the longest frame.
    a_left_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left < CNT_W'(MAX_BITS))
        else $error("bit count out of range");

    // A fresh job is taken only when the current one has run out.
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_pop |-> (r_left == '0) && i_job_valid)
        else $error("job popped while serializing");

endmodule

`default_nettype wire

// ----- rtl/led_driver_serial_framer_top.sv -----
// Top level of the LED driver serial framer: one bit result per serial bit.
// With the serializer idle, a request passes the queue, then the output register; bits
// follow one per cycle while results are popped, so a request holds the serializer for
// its 8 to 14 bits, and a burst byte with no open burst produces no bits. A two-entry
// queue takes requests while the serializer runs. Synchronous active-low reset empties
// the queue and output register and closes any open burst. Depends on all ldsf_ files.
`timescale 1ns / 1ps
`default_nettype none

module led_driver_serial_framer_top (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [1:0] i_mode,
    input  wire logic [7:0] i_value,
    input  wire logic [6:0] i_address,
    input  wire logic       i_last,
    output logic            empty,
    input  wire logic       pop,
    output logic            o_data_bit,
    output logic            o_frame_start,
    output logic            o_frame_end,
    output logic            o_run_last
);
    import ldsf_pkg::*;

    logic accept;
    logic job_push;
    t_job front_job;
    logic q_valid;
    t_job q_job;
    logic q_pop;

    assign accept = push & ~full;

    ldsf_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_mode    (i_mode),
        .i_value   (i_value),
        .i_address (i_address),
        .i_last    (i_last),
        .o_push    (job_push),
        .o_job     (front_job)
    );

    ldsf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (front_job),
        .i_pop   (q_pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    ldsf_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (q_valid),
        .i_job         (q_job),
        .o_job_pop     (q_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_data_bit    (o_data_bit),
        .o_frame_start (o_frame_start),
        .o_frame_end   (o_frame_end),
        .o_run_last    (o_run_last)
    );

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for led_driver_serial_framer_top: predicts every serial bit
// and its frame marks from each accepted request, then compares the popped results in order.
// Depends on ldsf_pkg and the led_driver_serial_framer_top RTL.
`timescale 1ns / 1ps

module tb_top;

    import ldsf_pkg::*;

    typedef struct packed {
        logic data_bit;
        logic frame_start;
        logic frame_end;
        logic run_last;
    } t_serial_bit;

    logic       i_clk;
    logic       i_rst_n;
    logic       push;
    logic       full;
    logic [1:0] i_mode;
    logic [7:0] i_value;
    logic [6:0] i_address;
    logic       i_last;
    logic       empty;
    logic       pop;
    logic       o_data_bit;
    logic       o_frame_start;
    logic       o_frame_end;
    logic       o_run_last;

    t_serial_bit pending_bits[$];
    logic        burst_is_open;
    int          mismatch_count;
    int          framed_requests;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_off_cycles;

    led_driver_serial_framer_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_mode        (i_mode),
        .i_value       (i_value),
        .i_address     (i_address),
        .i_last        (i_last),
        .empty         (empty),
        .pop           (pop),
        .o_data_bit    (o_data_bit),
        .o_frame_start (o_frame_start),
        .o_frame_end   (o_frame_end),
        .o_run_last    (o_run_last)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #10 i_clk = ~i_clk;

    initial begin
        #(20 * 400000);
        $display("led_driver_serial_framer_top: mismatch");
        $finish;
    end

    // Appends the serial bits that one accepted request produces.
    task automatic frame_request(input t_mode mode, input logic [7:0] value,
                                 input logic [6:0] address, input logic last);
        logic [31:0] word;
        int          len;
        logic        first;
        logic        closes;
        t_serial_bit one_bit;
        logic [31:0] addr_bits;
        word      = '0;
        len       = 0;
        first     = 1'b1;
        closes    = 1'b1;
        addr_bits = 32'(address) & ((32'd1 << ADDRESS_BITS) - 1);
        case (mode)
            MODE_COMMAND: begin
                word = {20'd0, ID_COMMAND, value, 1'b0};
                len  = 12;
                burst_is_open = 1'b0;
            end
            MODE_NIBBLE: begin
                word = ((32'(ID_WRITE) << ADDRESS_BITS) | addr_bits) << 4 | 32'(value[7:4]);
                len  = 7 + ADDRESS_BITS;
                burst_is_open = 1'b0;
            end
            MODE_BURST: begin
                word   = (32'(ID_WRITE) << ADDRESS_BITS) | addr_bits;
                len    = 3 + ADDRESS_BITS;
                closes = 1'b0;
                burst_is_open = 1'b1;
            end
            default: begin
                if (!burst_is_open) begin
                    return;
                end
                word  = 32'(value);
                len   = 8;
                first = 1'b0;
                if (last) begin
                    burst_is_open = 1'b0;
                end else begin
                    closes = 1'b0;
                end
            end
        endcase
        if (len > MAX_BITS) begin
            word = word >> (len - MAX_BITS);
            len  = MAX_BITS;
        end
        for (int i = 0; i < len; i++) begin
            one_bit.data_bit    = word[len - 1 - i];
            one_bit.frame_start = first && (i == 0);
            one_bit.frame_end   = closes && (i == len - 1);
            one_bit.run_last    = (i == len - 1);
            pending_bits.push_back(one_bit);
        end
        framed_requests++;
    endtask

    task automatic write_request(input t_mode mode, input logic [7:0] value,
                                 input logic [6:0] address, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            push      = 1'b0;
            i_mode    = 2'($urandom);
            i_value   = 8'($urandom);
            i_address = 7'($urandom);
            i_last    = 1'($urandom);
        end
        @(negedge i_clk);
        push      = 1'b1;
        i_mode    = mode;
        i_value   = value;
        i_address = address;
        i_last    = last;
        do begin
            @(posedge i_clk);
        end while (full);
        frame_request(mode, value, address, last);
    endtask

    always @(negedge i_clk) begin
        if (hold_off_cycles > 0) begin
            pop = 1'b0;
            hold_off_cycles--;
        end else begin
            pop = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic note_mismatch(input string what, input t_serial_bit want,
                                 input t_serial_bit got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t: %s: expected data/start/end/run_last=%b%b%b%b, got %b%b%b%b",
                     $realtime, what, want.data_bit, want.frame_start, want.frame_end,
                     want.run_last, got.data_bit, got.frame_start, got.frame_end,
                     got.run_last);
        end
    endtask

    always @(posedge i_clk) begin
        t_serial_bit got;
        t_serial_bit want;
        if (i_rst_n && pop && !empty) begin
            got = {o_data_bit, o_frame_start, o_frame_end, o_run_last};
            if (pending_bits.size() == 0) begin
                note_mismatch("unexpected bit", '0, got);
            end else begin
                want = pending_bits.pop_front();
                if (got.data_bit !== want.data_bit) begin
                    note_mismatch("data_bit", want, got);
                end
                if (got.frame_start !== want.frame_start) begin
                    note_mismatch("frame_start", want, got);
                end
                if (got.frame_end !== want.frame_end) begin
                    note_mismatch("frame_end", want, got);
                end
                if (got.run_last !== want.run_last) begin
                    note_mismatch("run_last", want, got);
                end
            end
        end
    end

    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_request(MODE_COMMAND, 8'h00, 7'h00, 1'b0);
        write_request(MODE_COMMAND, 8'hff, 7'h7f, 1'b1);
        write_request(MODE_COMMAND, 8'ha5, 7'h2a, 1'b0);
        write_request(MODE_NIBBLE, 8'hf0, 7'h00, 1'b0);
        write_request(MODE_NIBBLE, 8'h0f, 7'h7f, 1'b1);
        write_request(MODE_BYTE, 8'hff, 7'h7f, 1'b1);
        write_request(MODE_BURST, 8'h00, 7'h7f, 1'b0);
        write_request(MODE_BYTE, 8'h00, 7'h00, 1'b0);
        write_request(MODE_BYTE, 8'hff, 7'h00, 1'b0);
        write_request(MODE_BYTE, 8'h5a, 7'h00, 1'b1);
        write_request(MODE_BYTE, 8'h3c, 7'h00, 1'b1);
        write_request(MODE_BURST, 8'hff, 7'h00, 1'b1);
        write_request(MODE_BYTE, 8'h81, 7'h55, 1'b0);
        write_request(MODE_COMMAND, 8'h01, 7'h00, 1'b0);
        write_request(MODE_BURST, 8'h00, 7'h15, 1'b0);
        write_request(MODE_BURST, 8'h00, 7'h6a, 1'b0);
        write_request(MODE_BYTE, 8'h7e, 7'h00, 1'b1);
        write_request(MODE_BURST, 8'h00, 7'h40, 1'b0);
        write_request(MODE_NIBBLE, 8'h9c, 7'h33, 1'b0);
        write_request(MODE_BURST, 8'h00, 7'h01, 1'b0);
        write_request(MODE_BYTE, 8'hc3, 7'h00, 1'b0);
        write_request(MODE_BYTE, 8'h24, 7'h00, 1'b1);
    endtask

    task automatic test_random(input int count, input int send_pct, input int stall_pct);
        int start_count;
        int byte_count;
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        start_count    = framed_requests;
        while (framed_requests - start_count < count) begin
            if ($urandom_range(99) < 65) begin
                write_request(MODE_BURST, 8'($urandom), 7'($urandom), 1'($urandom));
                byte_count = $urandom_range(1, 4);
                for (int k = 0; k < byte_count; k++) begin
                    write_request(MODE_BYTE, 8'($urandom), 7'($urandom),
                                  (k == byte_count - 1) ? ($urandom_range(9) != 0) : 1'b0);
                end
            end else begin
                write_request(t_mode'($urandom_range(3)), 8'($urandom), 7'($urandom),
                              1'($urandom));
            end
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 150;
        for (int k = 0; k < 12; k++) begin
            write_request(t_mode'($urandom_range(2)), 8'($urandom), 7'($urandom),
                          1'($urandom));
        end
    endtask

    initial begin
        push            = 1'b0;
        i_mode          = MODE_COMMAND;
        i_value         = '0;
        i_address       = '0;
        i_last          = 1'b0;
        pop             = 1'b0;
        i_rst_n         = 1'b0;
        burst_is_open   = 1'b0;
        mismatch_count  = 0;
        framed_requests = 0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_off_cycles = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(50, 0, 0);
        test_random(50, 48, 0);
        test_backpressure();
        test_random(50, 0, 48);
        test_random(50, 26, 26);

        @(negedge i_clk);
        push = 1'b0;
        while (pending_bits.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0 && pending_bits.size() == 0) begin
            $display("led_driver_serial_framer_top: match");
        end else begin
            $display("led_driver_serial_framer_top: mismatch");
        end
        $finish;
    end

endmodule

// ----- led_driver_serial_framer_top.f -----
rtl/ldsf_pkg.sv
rtl/ldsf_front.sv
rtl/ldsf_queue.sv
rtl/ldsf_back.sv
rtl/led_driver_serial_framer_top.sv
tb/sv/tb_top.sv
